FILE: rtl/ppt_pkg.sv
// Shared types, fixed-point constants and the CORDIC angle table of the pure pursuit tracker.
// No dependencies; used by ppt_cordic, ppt_div and pure_pursuit_tracker_top in rtl/.
package ppt_pkg;

    localparam int CW           = 36;   // CORDIC x/y datapath width
    localparam int ZW           = 20;   // CORDIC angle width, Q16
    localparam int CORDIC_STEPS = 16;

    localparam int PI_Q12          = 12868;
    localparam int HALF_PI_Q12     = 6434;
    localparam int TWO_PI_Q12      = 25736;
    localparam int HALF_PI_Q16     = 102944;
    localparam int CORDIC_GAIN_Q16 = 39797;

    localparam int NUM_W = 27;           // divider dividend / quotient width
    localparam int DEN_W = 25;           // divider divisor width

    // input item function codes
    localparam logic FN_LOAD = 1'b0;
    localparam logic FN_POSE = 1'b1;

    typedef logic signed [CW-1:0] t_cval;
    typedef logic signed [ZW-1:0] t_zval;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_ctl;

    typedef enum logic [2:0] {
        CFG_LOOK_AHEAD = 3'd0,
        CFG_MAX_LIN    = 3'd1,
        CFG_MIN_LIN    = 3'd2,
        CFG_MAX_ANG    = 3'd3,
        CFG_END_TOL    = 3'd4,
        CFG_END_TURN   = 3'd5
    } t_cfg_idx;

    // atan(2^-i) in Q16
    function automatic t_zval atan_tab(input logic [3:0] i);
        t_zval v;
        begin
            unique case (i)
                4'd0:  v = 20'sd51472;
                4'd1:  v = 20'sd30386;
                4'd2:  v = 20'sd16055;
                4'd3:  v = 20'sd8150;
                4'd4:  v = 20'sd4091;
                4'd5:  v = 20'sd2047;
                4'd6:  v = 20'sd1024;
                4'd7:  v = 20'sd512;
                4'd8:  v = 20'sd256;
                4'd9:  v = 20'sd128;
                4'd10: v = 20'sd64;
                4'd11: v = 20'sd32;
                4'd12: v = 20'sd16;
                4'd13: v = 20'sd8;
                4'd14: v = 20'sd4;
                default: v = 20'sd2;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/ppt_path_mem.sv
// Waypoint store: one write port, one read port with registered read data.
// Each entry holds {y, x}. Depends on nothing.
module ppt_path_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [15:0] i_wx,
    input  logic signed [15:0] i_wy,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [15:0] o_rx,
    output logic signed [15:0] o_ry
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wy, i_wx};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rx = r_rdata[15:0];
    assign o_ry = r_rdata[31:16];

endmodule

FILE: rtl/ppt_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on ppt_pkg (widths, angle table).
module ppt_cordic
    import ppt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_ctl i_ctl,
    input  t_cval       i_x,
    input  t_cval       i_y,
    input  t_zval       i_z,
    output logic        o_done,
    output t_cval       o_y,
    output t_zval       o_z
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_step, n_step;
    logic        r_vec, n_vec;
    t_cval       r_x, n_x, r_y, n_y;
    t_zval       r_z, n_z;

    t_cval w_sx, w_sy;
    logic  w_ccw;

    assign w_sx  = r_x >>> r_step;
    assign w_sy  = r_y >>> r_step;
    // vectoring drives y to zero, rotation drives z to zero
    assign w_ccw = r_vec ? r_y[CW-1] : !r_z[ZW-1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_vec  = r_vec;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_step = 4'd0;
            n_vec  = i_ctl.vectoring;
            n_x    = i_x;
            n_y    = i_y;
            n_z    = i_z;
        end else if (r_busy) begin
            if (w_ccw) begin
                n_x = r_x - w_sy;
                n_y = r_y + w_sx;
                n_z = r_z - atan_tab(r_step);
            end else begin
                n_x = r_x + w_sy;
                n_y = r_y - w_sx;
                n_z = r_z + atan_tab(r_step);
            end
            n_step = r_step + 4'd1;
            if (r_step == 4'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_vec  <= n_vec;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_done = r_done;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

FILE: rtl/ppt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ppt_pkg (operand widths).
module ppt_div
    import ppt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int RW = DEN_W + 1;

    logic             r_busy, r_done;
    logic [4:0]       r_cnt;
    logic [NUM_W-1:0] r_num, r_quo;
    logic [DEN_W-1:0] r_den;
    logic [RW-1:0]    r_rem;

    logic [RW-1:0] w_rem_sh;
    logic [RW:0]   w_sub;
    logic          w_ge;

    assign w_rem_sh = {r_rem[RW-2:0], r_num[NUM_W-1]};
    assign w_sub    = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_ge     = !w_sub[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_cnt <= 5'd0;
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_sub[RW-1:0] : w_rem_sh;
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/pure_pursuit_tracker_top.sv
// Pure pursuit tracker top: path store, look-ahead search, control law sequencer.
// Depends on ppt_pkg, ppt_path_mem, ppt_cordic, ppt_div.
//
//  channel     dir  fields
//  s_axis_*    in   tdata: point_x, point_y, pose_x, pose_y, pose_theta; tuser: func, first_point
//  m_axis_*    out  tdata: linear_speed, angular_speed; tuser: at_end
//  i_cfg_*     in   register index / data write, no read-back
//
// A load transfer leaves tready high in S_IDLE. A pose tick keeps tready low while it walks
// the points from the kept target index (S_RD, S_SQ, S_CMP for each point); then the shared
// CORDIC runs twice and the shared divider twice. An arrival skips both, and a vehicle that
// sits on the target skips the first CORDIC run.
// Reset is synchronous active low and clears control state; the path memory is not cleared.
// A finished result sits in the output register; a tick stalls in S_OUT while it is full and not taken.
module pure_pursuit_tracker_top
    import ppt_pkg::*;
#(
    parameter int PATH_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // [15:0] point_x, [31:16] point_y, [47:32] pose_x,
                                        // [63:48] pose_y, [78:64] pose_theta, [79] zero
    input  logic [1:0]  s_axis_tuser,   // [0] func, [1] first_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [14:0] linear_speed, [30:15] angular_speed, [31] zero
    output logic [0:0]  m_axis_tuser,   // [0] at_end
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    localparam int AW      = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int COUNT_W = $clog2(PATH_DEPTH + 1);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_RD    = 16'h0002,
        S_SQ    = 16'h0004,
        S_CMP   = 16'h0008,
        S_END   = 16'h0010,
        S_ATAN  = 16'h0020,
        S_ALPHA = 16'h0040,
        S_SINGO = 16'h0080,
        S_SIN   = 16'h0100,
        S_KGO   = 16'h0200,
        S_K     = 16'h0400,
        S_LGO   = 16'h0800,
        S_L     = 16'h1000,
        S_MUL   = 16'h2000,
        S_ANG   = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

    t_state r_state;

    // configuration
    logic [14:0]        r_cfg_la, r_cfg_vmax, r_cfg_vmin, r_cfg_wmax, r_cfg_tol;
    logic signed [15:0] r_cfg_end;

    // path bookkeeping
    logic [COUNT_W-1:0] r_count;
    logic [AW-1:0]      r_target, r_idx;

    // per-tick working registers
    logic signed [15:0] r_px, r_py;
    logic signed [14:0] r_theta;
    logic [29:0]        r_l2, r_tol2;
    logic signed [16:0] r_dx, r_dy;
    logic [32:0]        r_sqx, r_sqy;
    logic [33:0]        r_d2;
    logic signed [15:0] r_atan, r_alpha;
    logic signed [13:0] r_s;
    logic signed [24:0] r_k;
    logic signed [31:0] r_pa;
    logic signed [40:0] r_pk;
    logic [14:0]        r_lin;
    logic signed [15:0] r_ang;
    logic               r_arr;

    // output register
    logic               r_out_valid;
    logic [14:0]        r_out_lin;
    logic signed [15:0] r_out_ang;
    logic               r_out_end;

    // input fields
    logic               w_func, w_first;
    logic signed [15:0] w_ptx, w_pty, w_posx, w_posy;
    logic signed [14:0] w_theta;
    logic               w_acc;

    assign w_func  = s_axis_tuser[0];
    assign w_first = s_axis_tuser[1];
    assign w_ptx   = s_axis_tdata[15:0];
    assign w_pty   = s_axis_tdata[31:16];
    assign w_posx  = s_axis_tdata[47:32];
    assign w_posy  = s_axis_tdata[63:48];
    assign w_theta = s_axis_tdata[78:64];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // ---------------- path memory ----------------
    logic               w_we, w_room;
    logic [AW-1:0]      w_waddr;
    logic signed [15:0] w_rx, w_ry;
    logic [COUNT_W-1:0] w_cm1;
    logic [AW-1:0]      w_last;

    assign w_room  = r_count < COUNT_W'(PATH_DEPTH);
    assign w_we    = w_acc && (w_func == FN_LOAD) && (w_first || w_room);
    assign w_waddr = w_first ? '0 : r_count[AW-1:0];
    assign w_cm1   = r_count - COUNT_W'(1);
    assign w_last  = w_cm1[AW-1:0];

    ppt_path_mem #(
        .DEPTH (PATH_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wx    (w_ptx),
        .i_wy    (w_pty),
        .i_raddr (r_idx),
        .o_rx    (w_rx),
        .o_ry    (w_ry)
    );

    // ---------------- distance ----------------
    logic signed [16:0] w_dx, w_dy;
    logic signed [33:0] w_sqx, w_sqy;
    logic [33:0]        w_d2;
    logic               w_far, w_arrive, w_zero;

    assign w_dx  = {w_rx[15], w_rx} - {r_px[15], r_px};
    assign w_dy  = {w_ry[15], w_ry} - {r_py[15], r_py};
    assign w_sqx = w_dx * w_dx;
    assign w_sqy = w_dy * w_dy;
    assign w_d2  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_far = w_d2 >= {4'b0, r_l2};
    assign w_arrive = (r_target == w_last) && (r_d2 < {4'b0, r_tol2});
    assign w_zero   = (r_dx == 17'sd0) && (r_dy == 17'sd0);

    // ---------------- CORDIC ----------------
    t_cordic_ctl w_cctl;
    t_cval       w_cx, w_cy, w_vx, w_vy, w_cy_out, w_yr, w_sr;
    t_zval       w_cz, w_cz_out, w_zr, w_z0;
    logic        w_cdone;
    logic signed [15:0] w_atan, w_af;
    logic signed [16:0] w_al, w_alw;

    assign w_vx = t_cval'(r_dx) <<< 14;
    assign w_vy = t_cval'(r_dy) <<< 14;

    // fold alpha into [-pi/2, pi/2] for the sine rotation
    always_comb begin
        if (r_alpha > 16'(HALF_PI_Q12)) begin
            w_af = 16'(PI_Q12) - r_alpha;
        end else if (r_alpha < -16'sd6434) begin
            w_af = -16'sd12868 - r_alpha;
        end else begin
            w_af = r_alpha;
        end
    end
    assign w_z0 = t_zval'(w_af) <<< 4;

    always_comb begin
        w_cctl.start     = ((r_state == S_END) && !w_arrive && !w_zero) ||
                           (r_state == S_SINGO);
        w_cctl.vectoring = (r_state == S_END);
        if (r_state == S_END) begin
            // pre-rotate left half plane by +-pi/2
            if (r_dx < 0) begin
                if (r_dy >= 0) begin
                    w_cx = w_vy;
                    w_cy = -w_vx;
                    w_cz = t_zval'(HALF_PI_Q16);
                end else begin
                    w_cx = -w_vy;
                    w_cy = w_vx;
                    w_cz = -t_zval'(HALF_PI_Q16);
                end
            end else begin
                w_cx = w_vx;
                w_cy = w_vy;
                w_cz = '0;
            end
        end else begin
            w_cx = t_cval'(CORDIC_GAIN_Q16);
            w_cy = '0;
            w_cz = w_z0;
        end
    end

    ppt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cctl),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .i_z     (w_cz),
        .o_done  (w_cdone),
        .o_y     (w_cy_out),
        .o_z     (w_cz_out)
    );

    assign w_zr   = w_cz_out + t_zval'(8);
    assign w_atan = w_zr[ZW-1:4];
    assign w_al   = {r_atan[15], r_atan} - {{2{r_theta[14]}}, r_theta};

    always_comb begin
        if (w_al > 17'sd12868) begin
            w_alw = w_al - 17'sd25736;
        end else if (w_al < -17'sd12868) begin
            w_alw = w_al + 17'sd25736;
        end else begin
            w_alw = w_al;
        end
    end

    assign w_yr = w_cy_out + t_cval'(8);
    assign w_sr = w_yr >>> 4;

    // ---------------- divider ----------------
    logic             w_dstart, w_ddone;
    logic [NUM_W-1:0] w_dnum, w_dquo;
    logic [DEN_W-1:0] w_dden;
    logic [13:0]      w_sabs;
    logic [24:0]      w_kabs;
    logic [14:0]      w_leff;
    logic signed [24:0] w_kq;

    assign w_sabs = r_s[13] ? 14'(-r_s) : 14'(r_s);
    assign w_kabs = r_k[24] ? 25'(-r_k) : 25'(r_k);
    assign w_leff = (r_cfg_la == 15'd0) ? 15'd1 : r_cfg_la;
    assign w_kq   = {1'b0, w_dquo[23:0]};

    assign w_dstart = (r_state == S_KGO) || (r_state == S_LGO);
    always_comb begin
        if (r_state == S_KGO) begin
            w_dnum = {3'b0, w_sabs[12:0], 11'b0};
            w_dden = {10'b0, w_leff};
        end else begin
            w_dnum = {r_cfg_vmax, 12'b0};
            w_dden = {w_kabs[23:0], 1'b0} + 25'd4096;
        end
    end

    ppt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quo   (w_dquo)
    );

    // ---------------- angular law ----------------
    logic signed [31:0] w_pa_adj, w_a;
    logic signed [40:0] w_pk_adj, w_b, w_sum;
    logic signed [16:0] w_wm, w_ac;
    logic signed [15:0] w_angc;

    assign w_wm     = {2'b00, r_cfg_wmax};
    assign w_pa_adj = r_pa + (r_pa[31] ? 32'sd4095 : 32'sd0);
    assign w_a      = w_pa_adj >>> 12;
    assign w_pk_adj = r_pk + (r_pk[40] ? 41'sd8191 : 41'sd0);
    assign w_b      = w_pk_adj >>> 13;

    always_comb begin
        if (w_a > 32'(w_wm)) begin
            w_ac = w_wm;
        end else if (w_a < -32'(w_wm)) begin
            w_ac = -w_wm;
        end else begin
            w_ac = w_a[16:0];
        end
    end
    assign w_sum = w_b + 41'(w_ac);
    always_comb begin
        if (w_sum > 41'(w_wm)) begin
            w_angc = 16'(w_wm);
        end else if (w_sum < -41'(w_wm)) begin
            w_angc = 16'(-w_wm);
        end else begin
            w_angc = w_sum[15:0];
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_la   <= 15'd205;
            r_cfg_vmax <= 15'd12288;
            r_cfg_vmin <= 15'd819;
            r_cfg_wmax <= 15'd8192;
            r_cfg_tol  <= 15'd102;
            r_cfg_end  <= 16'sd24576;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_LOOK_AHEAD: r_cfg_la   <= i_cfg_data[14:0];
                CFG_MAX_LIN:    r_cfg_vmax <= i_cfg_data[14:0];
                CFG_MIN_LIN:    r_cfg_vmin <= i_cfg_data[14:0];
                CFG_MAX_ANG:    r_cfg_wmax <= i_cfg_data[14:0];
                CFG_END_TOL:    r_cfg_tol  <= i_cfg_data[14:0];
                CFG_END_TURN:   r_cfg_end  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    logic w_load_out;
    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && w_func == FN_LOAD) begin
                        if (w_first) begin
                            r_count  <= COUNT_W'(1);
                            r_target <= '0;
                        end else if (w_room) begin
                            r_count <= r_count + COUNT_W'(1);
                        end
                    end else if (w_acc && r_count != '0) begin
                        r_state <= S_RD;
                    end
                end
                S_RD:  r_state <= S_SQ;
                S_SQ:  r_state <= S_CMP;
                S_CMP: begin
                    if (w_far || r_idx == w_last) begin
                        r_target <= r_idx;
                        r_state  <= S_END;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_END: begin
                    if (w_arrive) begin
                        r_state <= S_OUT;
                    end else if (w_zero) begin
                        r_state <= S_ALPHA;
                    end else begin
                        r_state <= S_ATAN;
                    end
                end
                S_ATAN:  if (w_cdone) r_state <= S_ALPHA;
                S_ALPHA: r_state <= S_SINGO;
                S_SINGO: r_state <= S_SIN;
                S_SIN:   if (w_cdone) r_state <= S_KGO;
                S_KGO:   r_state <= S_K;
                S_K:     if (w_ddone) r_state <= S_LGO;
                S_LGO:   r_state <= S_L;
                S_L:     if (w_ddone) r_state <= S_MUL;
                S_MUL:   r_state <= S_ANG;
                S_ANG:   r_state <= S_OUT;
                S_OUT:   if (w_load_out) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_px    <= w_posx;
            r_py    <= w_posy;
            r_theta <= w_theta;
            r_idx   <= r_target;
            r_l2    <= r_cfg_la * r_cfg_la;
            r_tol2  <= r_cfg_tol * r_cfg_tol;
        end
        if (r_state == S_SQ) begin
            r_dx  <= w_dx;
            r_dy  <= w_dy;
            r_sqx <= w_sqx[32:0];
            r_sqy <= w_sqy[32:0];
        end
        if (r_state == S_CMP) begin
            r_d2 <= w_d2;
            if (!(w_far || r_idx == w_last)) begin
                r_idx <= r_idx + AW'(1);
            end
        end
        if (r_state == S_END) begin
            r_arr  <= w_arrive;
            r_lin  <= '0;
            r_ang  <= r_cfg_end;
            r_atan <= '0;
        end
        if (r_state == S_ATAN && w_cdone) begin
            r_atan <= w_atan;
        end
        if (r_state == S_ALPHA) begin
            r_alpha <= w_alw[15:0];
        end
        if (r_state == S_SIN && w_cdone) begin
            if (w_sr > t_cval'(4096)) begin
                r_s <= 14'sd4096;
            end else if (w_sr < -t_cval'(4096)) begin
                r_s <= -14'sd4096;
            end else begin
                r_s <= w_sr[13:0];
            end
        end
        if (r_state == S_K && w_ddone) begin
            r_k <= r_s[13] ? -w_kq : w_kq;
        end
        if (r_state == S_L && w_ddone) begin
            r_lin <= (w_dquo[14:0] < r_cfg_vmin) ? r_cfg_vmin : w_dquo[14:0];
        end
        if (r_state == S_MUL) begin
            r_pa <= $signed({1'b0, r_cfg_wmax}) * r_alpha;
            r_pk <= r_k * $signed({1'b0, r_cfg_wmax});
        end
        if (r_state == S_ANG) begin
            r_ang <= w_angc;
        end
        if (w_load_out) begin
            r_out_lin <= r_lin;
            r_out_ang <= r_ang;
            r_out_end <= r_arr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_ang, r_out_lin};
    assign m_axis_tuser  = r_out_end;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(PATH_DEPTH))
        else $error("point count above path depth");

    a_target_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_target <= w_last))
        else $error("target index beyond last point");

    a_walk_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_idx <= w_last))
        else $error("search walked past last point");

    a_arrival_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[14:0] == 15'd0))
        else $error("arrival result with nonzero speed");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_we)
        else $error("path write during pose tick");
`endif

endmodule

FILE: bench/tb.sv
// Self-checking bench for pure_pursuit_tracker_top: streams path loads and pose ticks,
// predicts every command with a bit-accurate tracker model and compares field by field.
// Depends on ppt_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb
    import ppt_pkg::*;
();

    localparam int DEPTH = 256;

    typedef struct packed {
        logic        func;
        logic        first;
        logic [15:0] ptx, pty, posx, posy;
        logic [14:0] theta;
    } t_item;

    typedef struct packed {
        logic [14:0] lin;
        logic [15:0] ang;
        logic        at_end;
    } t_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_data = '0;

    pure_pursuit_tracker_top dut (.*);

    always #5 i_clk = ~i_clk;

    // tracker model state
    longint path_x[DEPTH], path_y[DEPTH];
    int     n_points, target_idx;
    bit     loaded;
    longint la_dist, vmax, vmin, wmax, end_tol, end_turn;

    t_item  pending_items[$];
    t_cmd   expected_cmds[$];
    int     mismatches = 0;
    bit     hold_off = 1'b0;
    bit     drain_pause = 1'b0;

    function automatic void queue_item(t_item it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void expect_cmd(t_cmd c);
        expected_cmds = {expected_cmds, c};
    endfunction

    function automatic longint asr(longint v, int s);
        return v >= 0 ? (v >>> s) : -((-v - 1) >>> s) - 1;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan_q16(int i);
        longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    function automatic longint heading_q12(longint dy, longint dx);
        longint x, y, z, t;
        x = dx * 16384; y = dy * 16384; z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin t = x; x = y; y = -t; z = HALF_PI_Q16; end
            else begin t = x; x = -y; y = t; z = -HALF_PI_Q16; end
        end
        for (int i = 0; i < 16; i++) begin
            t = x;
            if (y >= 0) begin
                x += asr(y, i); y -= asr(t, i); z += atan_q16(i);
            end else begin
                x -= asr(y, i); y += asr(t, i); z -= atan_q16(i);
            end
        end
        return asr(z + 8, 4);
    endfunction

    function automatic longint sine_q12(longint a);
        longint x, y, z, t;
        x = CORDIC_GAIN_Q16; y = 0;
        if (a > PI_Q12 / 2) a = PI_Q12 - a;
        else if (a < -(PI_Q12 / 2)) a = -PI_Q12 - a;
        z = a * 16;
        for (int i = 0; i < 16; i++) begin
            t = x;
            if (z >= 0) begin
                x -= asr(y, i); y += asr(t, i); z -= atan_q16(i);
            end else begin
                x += asr(y, i); y -= asr(t, i); z += atan_q16(i);
            end
        end
        return clip(asr(y + 8, 4), -4096, 4096);
    endfunction

    function automatic longint range2(longint px, longint py, int idx);
        longint dx, dy;
        dx = path_x[idx] - px; dy = path_y[idx] - py;
        return dx * dx + dy * dy;
    endfunction

    function automatic void set_reg(t_cfg_idx idx, longint v);
        case (idx)
            CFG_LOOK_AHEAD: la_dist = v & 16'h7fff;
            CFG_MAX_LIN:    vmax = v & 16'h7fff;
            CFG_MIN_LIN:    vmin = v & 16'h7fff;
            CFG_MAX_ANG:    wmax = v & 16'h7fff;
            CFG_END_TOL:    end_tol = v & 16'h7fff;
            default:        end_turn = $signed(16'(v));
        endcase
    endfunction

    // updates tracker state for one accepted item, queues the command it yields
    function automatic void track(t_item it);
        longint px, py, th, l2, d2, alpha, s, k, lin, ang, l;
        int last;
        bit found;
        t_cmd c;
        if (it.func == FN_LOAD) begin
            if (it.first) begin n_points = 0; target_idx = 0; end
            if (n_points < DEPTH) begin
                path_x[n_points] = $signed(it.ptx);
                path_y[n_points] = $signed(it.pty);
                n_points++;
                loaded = 1'b1;
            end
            return;
        end
        if (!loaded || n_points == 0 || target_idx >= n_points) return;
        px = $signed(it.posx); py = $signed(it.posy); th = $signed(it.theta);
        l2 = la_dist * la_dist;
        last = n_points - 1;
        found = 1'b0;
        for (int i = target_idx; i < n_points; i++)
            if (!found && range2(px, py, i) >= l2) begin target_idx = i; found = 1'b1; end
        if (!found) target_idx = last;
        d2 = range2(px, py, last);
        if (target_idx == last && d2 < end_tol * end_tol) begin
            c.lin = '0; c.ang = 16'(end_turn); c.at_end = 1'b1;
            expect_cmd(c);
            return;
        end
        alpha = heading_q12(path_y[target_idx] - py, path_x[target_idx] - px) - th;
        while (alpha > PI_Q12) alpha -= TWO_PI_Q12;
        while (alpha < -PI_Q12) alpha += TWO_PI_Q12;
        s = sine_q12(alpha);
        l = la_dist == 0 ? 1 : la_dist;
        k = (2 * s * 1024) / l;
        lin = (vmax * 4096) / (4096 + 2 * (k < 0 ? -k : k));
        if (lin < vmin) lin = vmin;
        ang = clip((wmax * alpha) / 4096, -wmax, wmax);
        ang = clip(ang + (k * wmax) / 8192, -wmax, wmax);
        c.lin = 15'(lin); c.ang = 16'(ang); c.at_end = 1'b0;
        expect_cmd(c);
    endfunction

    function automatic t_item load_pt(bit first, int x, int y);
        t_item it;
        it = '0;
        it.func = FN_LOAD; it.first = first; it.ptx = 16'(x); it.pty = 16'(y);
        it.posx = 16'($urandom); it.posy = 16'($urandom); it.theta = 15'($urandom);
        return it;
    endfunction

    function automatic t_item pose(int x, int y, int th);
        t_item it;
        it = '0;
        it.func = FN_POSE; it.first = $urandom_range(0, 1);
        it.ptx = 16'($urandom); it.pty = 16'($urandom);
        it.posx = 16'(x); it.posy = 16'(y); it.theta = 15'(th);
        return it;
    endfunction

    // sender: bursts and gaps
    int gap_left = 0, burst_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                track(pending_items.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0 || drain_pause || pending_items.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {1'b0, pending_items[0].theta, pending_items[0].posy,
                                     pending_items[0].posx, pending_items[0].pty,
                                     pending_items[0].ptx};
                    s_axis_tuser <= {pending_items[0].first, pending_items[0].func};
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 23;
        if (hold_off) m_axis_tready <= 1'b0;
        else if (stall_phase < 8) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    // monitor
    always @(posedge i_clk) begin
        t_cmd got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.lin = m_axis_tdata[14:0];
            got.ang = m_axis_tdata[30:15];
            got.at_end = m_axis_tuser[0];
            if (expected_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected command lin=%0d ang=%0d end=%0d",
                             got.lin, $signed(got.ang), got.at_end);
            end else begin
                want = expected_cmds.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "exp lin=%0d ang=%0d end=%0d, got lin=%0d ang=%0d end=%0d",
                            want.lin, $signed(want.ang), want.at_end,
                            got.lin, $signed(got.ang), got.at_end);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0)
            @(posedge i_clk);
        // a pose tick with no result may still be running
        repeat (1000) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int v);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_data <= 16'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic random_path(int n, int spread);
        int x, y;
        x = int'($urandom_range(0, 2 * spread)) - spread;
        y = int'($urandom_range(0, 2 * spread)) - spread;
        queue_item(load_pt(1'b1, x, y));
        for (int i = 1; i < n; i++) begin
            x = clip(x + int'($urandom_range(0, 600)) - 300, -32768, 32767);
            y = clip(y + int'($urandom_range(0, 600)) - 300, -32768, 32767);
            queue_item(load_pt(1'b0, x, y));
        end
    endtask

    task automatic random_poses(int n);
        int idx;
        for (int i = 0; i < n; i++) begin
            idx = $urandom_range(0, n_points > 0 ? n_points - 1 : 0);
            if ($urandom_range(0, 4) == 0)
                queue_item(pose($urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 25736) - 12868));
            else
                queue_item(pose(
                    clip(path_x[idx] + $urandom_range(0, 400) - 200, -32768, 32767),
                    clip(path_y[idx] + $urandom_range(0, 400) - 200, -32768, 32767),
                    $urandom_range(0, 25736) - 12868));
        end
    endtask

    initial begin
        n_points = 0; target_idx = 0; loaded = 1'b0;
        la_dist = 205; vmax = 12288; vmin = 819; wmax = 8192; end_tol = 102; end_turn = 24576;
        for (int i = 0; i < DEPTH; i++) begin path_x[i] = 0; path_y[i] = 0; end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tick with no path, extremes, arrival, on-target, rear target
        queue_item(pose(0, 0, 0));
        queue_item(load_pt(1'b1, 32767, -32768));
        queue_item(pose(-32768, 32767, 12868));
        queue_item(pose(-32768, 32767, -12868));
        queue_item(load_pt(1'b1, 1000, 0));
        queue_item(load_pt(1'b0, 2000, 0));
        queue_item(load_pt(1'b0, -2000, -32768));
        queue_item(pose(0, 0, 0));
        queue_item(pose(-3000, 1000, 16383));
        queue_item(pose(-2000, -32768, 0));
        queue_item(pose(-2050, -32760, -16384));
        queue_item(load_pt(1'b1, 0, 0));
        queue_item(pose(0, 0, 5000));
        queue_item(pose(32767, 32767, 12868));
        queue_item(load_pt(1'b1, -1000, 500));
        queue_item(pose(0, 0, 12868));
        queue_item(pose(-1000, 501, -12868));
        wait_idle();

        write_reg(CFG_LOOK_AHEAD, 0);
        write_reg(CFG_END_TOL, 0);
        write_reg(CFG_END_TURN, -32768);
        queue_item(load_pt(1'b1, 0, 0));
        queue_item(load_pt(1'b0, 100, 0));
        queue_item(pose(0, 0, 0));
        queue_item(pose(100, 0, 0));
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_LOOK_AHEAD, 32767); write_reg(CFG_MAX_LIN, 32767);
                    write_reg(CFG_MIN_LIN, 0); write_reg(CFG_MAX_ANG, 32767);
                    write_reg(CFG_END_TOL, 32767); write_reg(CFG_END_TURN, 32767);
                end
                1: begin
                    write_reg(CFG_LOOK_AHEAD, 1); write_reg(CFG_MAX_LIN, 0);
                    write_reg(CFG_MIN_LIN, 32767); write_reg(CFG_MAX_ANG, 0);
                    write_reg(CFG_END_TOL, 0); write_reg(CFG_END_TURN, 0);
                end
                default: begin
                    write_reg(CFG_LOOK_AHEAD, $urandom_range(50, 800));
                    write_reg(CFG_MAX_LIN, $urandom_range(0, 32767));
                    write_reg(CFG_MIN_LIN, $urandom_range(0, 4000));
                    write_reg(CFG_MAX_ANG, $urandom_range(0, 32767));
                    write_reg(CFG_END_TOL, $urandom_range(0, 400));
                    write_reg(CFG_END_TURN, $urandom_range(0, 65535) - 32768);
                end
            endcase
            // deep path only once; small paths keep ticks short
            if (phase == 3) begin
                random_path(262, 30000);
            end else begin
                random_path($urandom_range(1, 12), 32000);
            end
            wait_idle();
            random_poses(30);
            if (phase == 2) begin
                // receiver holds off while ticks keep coming
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_idle();
            for (int i = 0; i < 5; i++) begin
                queue_item(load_pt($urandom_range(0, 1),
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768));
                random_poses(4);
            end
            if (phase == 4) begin
                // sender pauses until every command is back
                while (pending_items.size() != 0) @(posedge i_clk);
                drain_pause = 1'b1;
                while (expected_cmds.size() != 0 || s_axis_tvalid) @(posedge i_clk);
                drain_pause = 1'b0;
            end
            wait_idle();
        end

        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end
endmodule
